### hdl/assembler_char_lexer_core_defines.svh
// Assertion macros for the assembler character lexer.
`ifndef ASSEMBLER_CHAR_LEXER_CORE_DEFINES_SVH
`define ASSEMBLER_CHAR_LEXER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication, checked on every rising clk outside reset
`define ACL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ACL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define ACL_ASSERT_NOW(lbl, ante, cons, msg)
`define ACL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hdl/acl_pkg.sv
// Shared codes and character constants for the assembler character lexer.
`timescale 1ns / 1ps
`default_nettype none

package acl_pkg;

	typedef enum logic [3:0] {
		K_NONE    = 4'd0,
		K_NUM     = 4'd1,
		K_NAME    = 4'd2,
		K_LABEL   = 4'd3,
		K_COMMENT = 4'd4,
		K_ADDR    = 4'd5,
		K_STRING  = 4'd6,
		K_FLOAT   = 4'd7,
		K_CHAR    = 4'd8
	} tok_class_t;

	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_OPEN       = 3'd1,
		EV_OPEN_EMPTY = 3'd2,
		EV_APPEND     = 3'd3,
		EV_CLOSE      = 3'd4,
		EV_ERROR      = 3'd5
	} lex_event_t;

	typedef enum logic [3:0] {
		ERR_OK       = 4'd0,
		ERR_ALPHA    = 4'd1,
		ERR_PERIOD   = 4'd2,
		ERR_QUOTE    = 4'd3,
		ERR_MINUS    = 4'd4,
		ERR_SEMI     = 4'd5,
		ERR_INVALID  = 4'd6,
		ERR_UNCLOSED = 4'd7,
		ERR_OVERFLOW = 4'd8
	} lex_error_t;

	localparam logic [7:0] CH_DQUOTE = 8'd34;
	localparam logic [7:0] CH_SQUOTE = 8'd39;
	localparam logic [7:0] CH_CR     = 8'd13;
	localparam logic [7:0] CH_TAB    = 8'd9;
	localparam logic [7:0] CH_SPACE  = 8'd32;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_PERIOD = 8'h2E;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_UNDER  = 8'h5F;

	localparam int          LINE_W   = 20;
	localparam logic [19:0] LINE_TOP = 20'hFFFFF;

endpackage

`default_nettype wire

### hdl/assembler_char_lexer_core.sv
// Assembler character lexer: one source byte or end-of-line in, one lexer event out.
//
//  channel  | dir | tuser               | tdata
//  ---------+-----+---------------------+----------------------------------------------
//  s_axis   | in  | command (1=EOL)     | char_in[7:0]
//  m_axis   | out | event_res[2:0]      | token_class, char_out, char_index,
//           |     |                     | error_code, line_number (52 bits in 56)
//
// One item per clock while the output is not stalled: the lexer state and the
// result in the output register both update at the input transfer.
// The output register frees up in the same cycle it is drained, so a stalled
// master only holds the input while its result is still waiting.
// arst_n clears the class, length, line count (to 1) and the halt flag.
// After an error every item answers with the held error until reset.
`timescale 1ns / 1ps
`default_nettype none
`include "assembler_char_lexer_core_defines.svh"

module assembler_char_lexer_core #(
	parameter int MAX_TOKEN_LEN  = 256,
	parameter int MAX_STRING_LEN = 65536
) (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,  // [7:0] char_in
	input  wire logic        s_axis_tuser,  // [0] command

	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// [3:0] token_class, [11:4] char_out, [27:12] char_index,
	// [31:28] error_code, [51:32] line_number, [55:52] zero
	output logic [55:0]      m_axis_tdata,
	output logic [2:0]       m_axis_tuser   // [2:0] event_res
);
	import acl_pkg::*;

	localparam int LEN_MAX = (MAX_STRING_LEN > MAX_TOKEN_LEN) ? MAX_STRING_LEN : MAX_TOKEN_LEN;
	localparam int LEN_W   = $clog2(LEN_MAX);
	localparam logic [LEN_W-1:0] STR_LAST = LEN_W'(MAX_STRING_LEN - 1);
	localparam logic [LEN_W-1:0] TOK_LAST = LEN_W'(MAX_TOKEN_LEN - 1);

	typedef enum logic [2:0] {
		ACT_IDLE,
		ACT_OPEN,
		ACT_APPEND,
		ACT_OPEN_EMPTY,
		ACT_CLOSE,
		ACT_FAIL
	} act_t;

	// lexer state
	tok_class_t        cls_q;
	logic [LEN_W-1:0]  len_q;
	logic [LINE_W-1:0] line_q;
	logic              halt_q;
	lex_error_t        err_q;

	// result register
	logic              out_valid_q;
	lex_event_t        out_ev_q;
	tok_class_t        out_cls_q;
	logic [7:0]        out_ch_q;
	logic [15:0]       out_idx_q;
	lex_error_t        out_err_q;
	logic [LINE_W-1:0] out_line_q;

	logic in_xfer;
	logic cmd;
	logic [7:0] c;

	act_t       act;
	tok_class_t act_cls;
	lex_error_t act_err;
	logic       is_text;

	tok_class_t        nxt_cls;
	logic [LEN_W-1:0]  nxt_len;
	logic [LINE_W-1:0] nxt_line;
	logic              nxt_halt;
	lex_error_t        nxt_err;
	lex_event_t        res_ev;
	tok_class_t        res_cls;
	logic [7:0]        res_ch;
	logic [15:0]       res_idx;
	lex_error_t        res_err;

	logic [LEN_W-1:0] base_len;
	logic [LEN_W-1:0] last_len;

	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_xfer       = s_axis_tvalid && s_axis_tready;
	assign cmd           = s_axis_tuser;
	assign c             = s_axis_tdata;
	assign is_text       = (cls_q == K_STRING) || (cls_q == K_CHAR) || (cls_q == K_COMMENT);

	// classify the byte against the current token class
	always_comb begin
		act     = ACT_IDLE;
		act_cls = cls_q;
		act_err = ERR_OK;
		if (cmd) begin
			if (cls_q == K_STRING || cls_q == K_CHAR) begin
				act     = ACT_FAIL;
				act_err = ERR_UNCLOSED;
			end else if (cls_q != K_NONE) begin
				act = ACT_CLOSE;
			end
		end else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A], CH_UNDER}) begin
			if (cls_q == K_NUM) begin
				act     = ACT_FAIL;
				act_err = ERR_ALPHA;
			end else if (cls_q == K_NONE) begin
				act     = ACT_OPEN;
				act_cls = K_NAME;
			end else begin
				act = ACT_APPEND;
			end
		end else if (c inside {[8'h30:8'h39]}) begin
			if (cls_q == K_NONE) begin
				act     = ACT_OPEN;
				act_cls = K_NUM;
			end else begin
				act = ACT_APPEND;
			end
		end else begin
			case (c)
				CH_PERIOD: begin
					if (cls_q == K_NONE) begin
						act     = ACT_OPEN;
						act_cls = K_FLOAT;
					end else if (cls_q == K_FLOAT) begin
						act     = ACT_FAIL;
						act_err = ERR_PERIOD;
					end else begin
						act = ACT_APPEND;
						// a period turns a number into a float
						if (cls_q == K_NUM)
							act_cls = K_FLOAT;
					end
				end
				CH_MINUS: begin
					if (cls_q == K_NUM || cls_q == K_FLOAT) begin
						act     = ACT_FAIL;
						act_err = ERR_MINUS;
					end else if (cls_q == K_NONE) begin
						act     = ACT_OPEN;
						act_cls = K_NUM;
					end else begin
						act = ACT_APPEND;
					end
				end
				CH_COLON: begin
					if (cls_q == K_NONE) begin
						act     = ACT_OPEN;
						act_cls = K_LABEL;
					end else if (is_text) begin
						act = ACT_APPEND;
					end else begin
						act     = ACT_FAIL;
						act_err = ERR_QUOTE;
					end
				end
				CH_DQUOTE, CH_SQUOTE: begin
					if (cls_q == K_NONE) begin
						act     = ACT_OPEN_EMPTY;
						act_cls = (c == CH_DQUOTE) ? K_STRING : K_CHAR;
					end else if ((c == CH_DQUOTE && cls_q == K_STRING) ||
					             (c == CH_SQUOTE && cls_q == K_CHAR)) begin
						act = ACT_CLOSE;
					end else if (is_text) begin
						act = ACT_APPEND;
					end else begin
						act     = ACT_FAIL;
						act_err = ERR_QUOTE;
					end
				end
				CH_SEMI: begin
					if (cls_q == K_NONE) begin
						act     = ACT_OPEN;
						act_cls = K_COMMENT;
					end else if (is_text) begin
						act = ACT_APPEND;
					end else begin
						act     = ACT_FAIL;
						act_err = ERR_SEMI;
					end
				end
				CH_AMP: begin
					if (cls_q == K_NONE) begin
						act     = ACT_OPEN;
						act_cls = K_ADDR;
					end else if (is_text) begin
						act = ACT_APPEND;
					end else begin
						act     = ACT_FAIL;
						act_err = ERR_INVALID;
					end
				end
				CH_SPACE, CH_TAB: begin
					if (is_text)
						act = ACT_APPEND;
					else if (cls_q != K_NONE)
						act = ACT_CLOSE;
				end
				CH_CR: begin
					act = ACT_IDLE;
				end
				default: begin
					if (is_text) begin
						act = ACT_APPEND;
					end else begin
						act     = ACT_FAIL;
						act_err = ERR_INVALID;
					end
				end
			endcase
		end
	end

	// apply the action, including the length limit check
	assign base_len = (act == ACT_OPEN) ? '0 : len_q;
	assign last_len = (act_cls == K_STRING || act_cls == K_CHAR) ? STR_LAST : TOK_LAST;

	always_comb begin
		nxt_cls  = cls_q;
		nxt_len  = len_q;
		nxt_line = line_q;
		nxt_halt = halt_q;
		nxt_err  = err_q;
		res_ev   = EV_NONE;
		res_cls  = cls_q;
		res_ch   = 8'd0;
		res_idx  = 16'd0;
		res_err  = ERR_OK;
		if (halt_q) begin
			res_ev  = EV_ERROR;
			res_err = err_q;
		end else begin
			case (act)
				ACT_IDLE: begin
					res_ev = EV_NONE;
				end
				ACT_OPEN, ACT_APPEND: begin
					if (base_len >= last_len) begin
						nxt_halt = 1'b1;
						nxt_err  = ERR_OVERFLOW;
						res_ev   = EV_ERROR;
						res_err  = ERR_OVERFLOW;
					end else begin
						nxt_cls = act_cls;
						nxt_len = base_len + 1'b1;
						res_ev  = (act == ACT_OPEN) ? EV_OPEN : EV_APPEND;
						res_cls = act_cls;
						res_ch  = c;
						res_idx = 16'(base_len);
					end
				end
				ACT_OPEN_EMPTY: begin
					nxt_cls = act_cls;
					nxt_len = '0;
					res_ev  = EV_OPEN_EMPTY;
					res_cls = act_cls;
				end
				ACT_CLOSE: begin
					nxt_cls = K_NONE;
					nxt_len = '0;
					res_ev  = EV_CLOSE;
				end
				ACT_FAIL: begin
					nxt_halt = 1'b1;
					nxt_err  = act_err;
					res_ev   = EV_ERROR;
					res_err  = act_err;
				end
				default: begin
					res_ev = EV_NONE;
				end
			endcase
			// line advances after a clean end of line; failing ones leave it
			if (cmd && act != ACT_FAIL && line_q != LINE_TOP)
				nxt_line = line_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cls_q  <= K_NONE;
			len_q  <= '0;
			line_q <= LINE_W'(1);
			halt_q <= 1'b0;
			err_q  <= ERR_OK;
		end else if (in_xfer) begin
			cls_q  <= nxt_cls;
			len_q  <= nxt_len;
			line_q <= nxt_line;
			halt_q <= nxt_halt;
			err_q  <= nxt_err;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_xfer) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload, line number is the one before the advance
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			out_ev_q   <= res_ev;
			out_cls_q  <= res_cls;
			out_ch_q   <= res_ch;
			out_idx_q  <= res_idx;
			out_err_q  <= res_err;
			out_line_q <= line_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_ev_q;
	assign m_axis_tdata  = {4'd0, out_line_q, out_err_q, out_idx_q, out_ch_q, out_cls_q};

	`ACL_ASSERT_NEXT(a_halt_sticky, halt_q, halt_q && $stable(err_q), "halt flag or held error changed")
	`ACL_ASSERT_NEXT(a_halt_reports, in_xfer && halt_q, m_axis_tvalid && (m_axis_tuser == EV_ERROR) && (m_axis_tdata[31:28] == err_q), "halted item did not report held error")
	`ACL_ASSERT_NOW(a_none_empty, cls_q == K_NONE, len_q == '0, "no open token but nonzero length")
	`ACL_ASSERT_NOW(a_line_nonzero, 1'b1, line_q != '0, "line count reached zero")

endmodule

`default_nettype wire
